/* hw/rtl/ocv_pkg.sv */
// Shared types, codes and arithmetic helpers for the online mean and covariance unit.
// No dependencies; every other file of the block but ocv_ram imports this package.
`timescale 1ns / 1ps

package ocv_pkg;

    localparam int VEC_LEN = 8;
    localparam int IDX_W = 3;
    localparam int COV_DEPTH = 64;
    localparam int COV_AW = 6;
    localparam int DIFF_W = 26;
    localparam int PROD_W = 52;
    localparam logic [15:0] MAX_COUNT = 16'hFFFF;
    localparam logic signed [63:0] COV_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] COV_MIN = 64'shFFFF_8000_0000_0000;
    localparam logic [IDX_W:0] LAST_IDX = (IDX_W + 1)'(VEC_LEN - 1);
    localparam logic [IDX_W:0] FEAT_LIM = (IDX_W + 1)'(VEC_LEN);

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_READ   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] value;
        logic [2:0]         row;
        logic [2:0]         col;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] mean_value;
        logic signed [47:0] covariance_value;
        logic [15:0]        sample_count;
        logic               empty_res;
        logic               overflow;
    } res_t;

    typedef struct packed {
        logic start;
        logic long_op;
    } div_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_RD,
        ST_MEAN_SUB,
        ST_MEAN_DIV,
        ST_COV,
        ST_RD_CHK,
        ST_RD_DIV,
        ST_RD_OUT
    } state_t;

    // Signed 64-bit add that clamps at the signed limits.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        begin
            s = a + b;
            if ((a[63] == b[63]) && (s[63] != a[63]))
            begin
                s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            end
            return s;
        end
    endfunction

endpackage

/* hw/rtl/ocv_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ocv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ocv_div.sv */
// Bit-serial signed divider: 64-bit dividend over a positive 16-bit divisor, truncating.
// Depends on ocv_pkg for the control struct.
`timescale 1ns / 1ps

module ocv_div
    import ocv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctl_t           ctl,
    input  logic signed [63:0] dividend,
    input  logic [15:0]        divisor,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic [16:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [63:0] mag;
    logic [17:0] rem_sh;

    assign mag = dividend[63] ? (64'd0 - dividend) : dividend;
    assign rem_sh = {rem_reg, q_reg[63]};

    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next = 17'd0;
            neg_next = dividend[63];
            if (ctl.long_op)
            begin
                q_next = mag;
                cnt_next = 7'd64;
            end
            else
            begin
                q_next = {mag[31:0], 32'd0};
                cnt_next = 7'd32;
            end
        end
        else if (cnt_reg != 7'd0)
        begin
            // Shift in one dividend bit and subtract where the divisor fits.
            if (rem_sh >= {2'b00, divisor})
            begin
                rem_next = 17'(rem_sh - {2'b00, divisor});
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[16:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

/* hw/rtl/online_mean_covariance_unit.sv */
// Top level of the streaming mean and covariance unit: control sequencer and datapath.
// Depends on ocv_pkg, ocv_ram and ocv_div.
`timescale 1ns / 1ps

// Streaming Welford accumulator over vectors of VEC_LEN Q8.8 elements. Each
// command item is a sample element, a read or a clear; the unused code is ignored.
// A sample element that does not close a vector is taken without a stall. The
// closing element starts the vector update, which keeps the port stalled until it
// is done: every element costs a mean RAM read, a subtract and a 32-step pass of
// the shared serial divider; then every covariance sum takes one read-modify-write
// through the covariance RAM, pipelined at one entry per cycle. A read runs a
// 64-step pass of the divider that scales the covariance sum by the sample count;
// an empty read or an out-of-range index skips the divider. Clear needs no
// clearing pass: each mean and covariance entry has a valid bit, and an entry
// whose bit is low reads as zero. Only a read returns a result item; it sits in an
// output register, so a new command is taken while it waits. Past 65535 samples,
// completed vectors are dropped and the overflow flag stays set until a clear.

module online_mean_covariance_unit
    import ocv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] elem_idx_reg;
    logic [15:0]      count_reg;
    logic             ovf_reg;
    logic [IDX_W-1:0] k_reg, r_reg, c_reg;
    logic             issue_done_reg;
    logic             p_valid_reg;
    logic [COV_AW-1:0] p_addr_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIFF_W-1:0] x_reg;
    logic signed [31:0] mean_old_reg;
    logic signed [DIFF_W-1:0] delta_arr [VEC_LEN];
    logic signed [DIFF_W-1:0] dev_arr [VEC_LEN];
    logic signed [15:0] buf_reg [VEC_LEN];
    logic [VEC_LEN-1:0] mean_vld_reg;
    logic [COV_DEPTH-1:0] cov_vld_reg;
    logic [IDX_W-1:0] rd_row_reg, rd_col_reg;
    logic signed [31:0] rd_mean_reg;
    logic signed [47:0] rd_cov_reg;
    logic signed [63:0] div_in;
    logic res_valid_reg, res_valid_next;
    res_t res_reg;

    logic accept;
    logic cmd_last;
    logic [IDX_W-1:0] cmd_idx;
    logic [IDX_W-1:0] cur_k;
    logic div_done;
    logic signed [63:0] div_q;
    div_ctl_t div_ctl;

    logic mean_we;
    logic [IDX_W-1:0] mean_raddr;
    logic signed [31:0] mean_rdata, mean_wdata, mean_cur, mean_new;
    logic cov_we;
    logic [COV_AW-1:0] cov_raddr;
    logic signed [63:0] cov_rdata, cov_old, cov_wdata;
    logic signed [DIFF_W-1:0] delta_now;
    logic rd_in_range;
    logic rd_do_div;
    logic out_free;
    logic cov_issue_last;

    assign accept = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_idx = ({1'b0, elem_idx_reg} >= FEAT_LIM) ? '0 : elem_idx_reg;
    assign cmd_last = ({1'b0, cmd_idx} == LAST_IDX);
    assign cur_k = k_reg;
    assign out_free = !res_valid_reg || !res_stall;

    // Mean store: read either for a read command or for the element being updated.
    assign mean_raddr = (state_reg == ST_IDLE) ? cmd.row : k_reg;
    assign mean_cur = mean_vld_reg[cur_k] ? mean_rdata : 32'sd0;
    assign delta_now = x_reg - DIFF_W'(mean_cur);
    assign mean_new = mean_old_reg + div_q[31:0];
    assign mean_we = (state_reg == ST_MEAN_DIV) && div_done;
    assign mean_wdata = mean_new;

    ocv_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_mean_ram (
        .clk   (clk),
        .we    (mean_we),
        .waddr (k_reg),
        .wdata (mean_wdata),
        .raddr (mean_raddr),
        .rdata (mean_rdata)
    );

    // Covariance sums: row-major, one read-modify-write per entry.
    assign cov_raddr = (state_reg == ST_IDLE) ? {cmd.row, cmd.col} : {r_reg, c_reg};
    assign cov_we = (state_reg == ST_COV) && p_valid_reg;
    assign cov_old = cov_vld_reg[p_addr_reg] ? cov_rdata : 64'sd0;
    assign cov_wdata = sat_add64(cov_old, 64'(prod_reg));
    assign cov_issue_last = ({1'b0, r_reg} == LAST_IDX) && ({1'b0, c_reg} == LAST_IDX);

    ocv_ram #(.WIDTH(64), .DEPTH(COV_DEPTH)) u_cov_ram (
        .clk   (clk),
        .we    (cov_we),
        .waddr (p_addr_reg),
        .wdata (cov_wdata),
        .raddr (cov_raddr),
        .rdata (cov_rdata)
    );

    assign rd_in_range = ({1'b0, rd_row_reg} < FEAT_LIM);
    assign rd_do_div = rd_in_range && ({1'b0, rd_col_reg} < FEAT_LIM) && (count_reg != 16'd0);

    // The divider captures its operand in the cycle that starts it: the fresh delta
    // during a vector update, the covariance sum just read during a read.
    assign div_in = (state_reg == ST_RD_CHK)
                  ? (cov_vld_reg[{rd_row_reg, rd_col_reg}] ? cov_rdata : 64'sd0)
                  : 64'(delta_now);

    ocv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_in),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        div_ctl = '{start: 1'b0, long_op: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_SAMPLE)
                    begin
                        if (cmd_last && (count_reg != MAX_COUNT))
                        begin
                            state_next = ST_MEAN_RD;
                        end
                    end
                    else if (cmd.action == ACT_READ)
                    begin
                        state_next = ST_RD_CHK;
                    end
                end
            end
            ST_MEAN_RD:
            begin
                state_next = ST_MEAN_SUB;
            end
            ST_MEAN_SUB:
            begin
                state_next = ST_MEAN_DIV;
            end
            ST_MEAN_DIV:
            begin
                if (div_done)
                begin
                    state_next = ({1'b0, k_reg} == LAST_IDX) ? ST_COV : ST_MEAN_RD;
                end
            end
            ST_COV:
            begin
                if (issue_done_reg && !p_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_CHK:
            begin
                state_next = rd_do_div ? ST_RD_DIV : ST_RD_OUT;
            end
            ST_RD_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RD_OUT;
                end
            end
            ST_RD_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Starts fire in the state before the divide state, with the operand on div_in.
        if ((state_reg == ST_MEAN_SUB))
        begin
            div_ctl = '{start: 1'b1, long_op: 1'b0};
        end
        else if ((state_reg == ST_RD_CHK) && rd_do_div)
        begin
            div_ctl = '{start: 1'b1, long_op: 1'b1};
        end
    end

    // A result is loaded when the read finishes and leaves once it is taken.
    assign res_valid_next = ((state_reg == ST_RD_OUT) && out_free) ||
                            (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            elem_idx_reg <= '0;
            count_reg <= 16'd0;
            ovf_reg <= 1'b0;
            k_reg <= '0;
            r_reg <= '0;
            c_reg <= '0;
            issue_done_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            mean_vld_reg <= '0;
            cov_vld_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.action == ACT_SAMPLE)
                        begin
                            if (cmd_last)
                            begin
                                elem_idx_reg <= '0;
                                if (count_reg == MAX_COUNT)
                                begin
                                    ovf_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 16'd1;
                                    k_reg <= '0;
                                end
                            end
                            else
                            begin
                                elem_idx_reg <= cmd_idx + IDX_W'(1);
                            end
                        end
                        else if (cmd.action == ACT_CLEAR)
                        begin
                            elem_idx_reg <= '0;
                            count_reg <= 16'd0;
                            ovf_reg <= 1'b0;
                            mean_vld_reg <= '0;
                            cov_vld_reg <= '0;
                        end
                    end
                end
                ST_MEAN_DIV:
                begin
                    if (div_done)
                    begin
                        mean_vld_reg[k_reg] <= 1'b1;
                        k_reg <= k_reg + IDX_W'(1);
                        r_reg <= '0;
                        c_reg <= '0;
                        issue_done_reg <= 1'b0;
                        p_valid_reg <= 1'b0;
                    end
                end
                ST_COV:
                begin
                    if (p_valid_reg)
                    begin
                        cov_vld_reg[p_addr_reg] <= 1'b1;
                    end
                    p_valid_reg <= !issue_done_reg;
                    if (!issue_done_reg)
                    begin
                        if (cov_issue_last)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else if ({1'b0, c_reg} == LAST_IDX)
                        begin
                            c_reg <= '0;
                            r_reg <= r_reg + IDX_W'(1);
                        end
                        else
                        begin
                            c_reg <= c_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && accept)
        begin
            if (cmd.action == ACT_SAMPLE)
            begin
                buf_reg[cmd_idx] <= cmd.value;
            end
            rd_row_reg <= cmd.row;
            rd_col_reg <= cmd.col;
        end
        if (state_reg == ST_MEAN_RD)
        begin
            // Q8.8 to Q8.16, keeping the sign.
            x_reg <= DIFF_W'($signed({buf_reg[k_reg], 8'd0}));
        end
        if (state_reg == ST_MEAN_SUB)
        begin
            mean_old_reg <= mean_cur;
            delta_arr[k_reg] <= delta_now;
        end
        if ((state_reg == ST_MEAN_DIV) && div_done)
        begin
            dev_arr[k_reg] <= x_reg - DIFF_W'(mean_new);
        end
        if (state_reg == ST_COV)
        begin
            prod_reg <= delta_arr[r_reg] * dev_arr[c_reg];
            p_addr_reg <= {r_reg, c_reg};
        end
        if (state_reg == ST_RD_CHK)
        begin
            rd_mean_reg <= (rd_in_range && mean_vld_reg[rd_row_reg]) ? mean_rdata : 32'sd0;
            rd_cov_reg <= 48'sd0;
        end
        if ((state_reg == ST_RD_DIV) && div_done)
        begin
            if (div_q > COV_MAX)
            begin
                rd_cov_reg <= COV_MAX[47:0];
            end
            else if (div_q < COV_MIN)
            begin
                rd_cov_reg <= COV_MIN[47:0];
            end
            else
            begin
                rd_cov_reg <= div_q[47:0];
            end
        end
        if ((state_reg == ST_RD_OUT) && out_free)
        begin
            res_reg.mean_value <= rd_mean_reg;
            res_reg.covariance_value <= rd_cov_reg;
            res_reg.sample_count <= count_reg;
            res_reg.empty_res <= (count_reg == 16'd0);
            res_reg.overflow <= ovf_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

/* hw/rtl/ocv_checker.sv */
// Port-level checker for the online mean and covariance unit, bound to the top level.
// Depends on ocv_pkg.
`timescale 1ns / 1ps

module ocv_checker
    import ocv_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input cmd_t cmd,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    // A result held under stall stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Only a read produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && !res_valid && (cmd.action != ACT_READ) |=> !res_valid)
        else $error("result without a read");

    // The empty flag follows the sample count.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.empty_res == (res.sample_count == 16'd0)))
        else $error("empty flag disagrees with sample count");

    // An empty read reports zero covariance.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.empty_res |-> (res.covariance_value == 48'sd0))
        else $error("nonzero covariance on empty read");

endmodule

bind online_mean_covariance_unit ocv_checker u_ocv_checker (.*);

/* sim/tb_online_mean_covariance_unit.sv */
// Testbench for online_mean_covariance_unit: directed table plus random commands,
// checked against a behavioral mean/covariance predictor. Depends on ocv_pkg.
`timescale 1ns / 1ps

module tb_online_mean_covariance_unit;
    import ocv_pkg::*;

    // Covariance reads are clamped to this signed 48-bit range.
    localparam longint RD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint RD_MIN = -RD_MAX - 1;
    // Idle cycles allowed with no item moving on either side before giving up.
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    online_mean_covariance_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the accumulator state.
    shortint elem_buf [8];
    longint  mean_sh [8];
    longint  sums_sh [8][8];
    int      count_sh;
    int      elem_idx;
    bit      ovf_sh;

    res_t    pending_reads [$];
    int      errors = 0;
    int      n_cmds = 0;
    int      n_reads = 0;
    int      n_vectors = 0;
    int      idle_cycles = 0;
    bit      quiet_phase = 1'b0;

    function automatic longint sat_sum(input longint a, input longint b);
        longint s;
        s = a + b;
        if ((a < 0) == (b < 0) && (s < 0) != (a < 0))
            s = (a < 0) ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s;
    endfunction

    task automatic stats_clear();
        for (int k = 0; k < 8; k++)
        begin
            mean_sh[k] = 0;
            for (int j = 0; j < 8; j++)
                sums_sh[k][j] = 0;
        end
        count_sh = 0;
        elem_idx = 0;
        ovf_sh = 1'b0;
    endtask

    // Welford update once the last element of a vector is in.
    task automatic fold_vector();
        longint x, delta [8], dev [8];
        if (count_sh >= 65535)
        begin
            ovf_sh = 1'b1;
            return;
        end
        count_sh++;
        n_vectors++;
        for (int k = 0; k < VEC_LEN; k++)
        begin
            x = longint'(elem_buf[k]) * 256;
            delta[k] = x - mean_sh[k];
            mean_sh[k] = longint'(int'(mean_sh[k] + delta[k] / count_sh));
            dev[k] = x - mean_sh[k];
        end
        for (int r = 0; r < VEC_LEN; r++)
            for (int c = 0; c < VEC_LEN; c++)
                sums_sh[r][c] = sat_sum(sums_sh[r][c], delta[r] * dev[c]);
    endtask

    // Applies one accepted command to the shadow state; has_res marks a read.
    task automatic predict_cmd(input cmd_t c, output bit has_res, output res_t r);
        longint cv;
        has_res = 1'b0;
        r = '0;
        case (action_t'(c.action))
            ACT_SAMPLE:
            begin
                elem_buf[elem_idx] = c.value;
                if (elem_idx == VEC_LEN - 1)
                begin
                    fold_vector();
                    elem_idx = 0;
                end
                else
                    elem_idx++;
            end
            ACT_CLEAR: stats_clear();
            ACT_READ:
            begin
                has_res = 1'b1;
                cv = 0;
                if (c.row < VEC_LEN)
                begin
                    r.mean_value = mean_sh[c.row][31:0];
                    if (c.col < VEC_LEN && count_sh != 0)
                    begin
                        cv = sums_sh[c.row][c.col] / count_sh;
                        if (cv > RD_MAX) cv = RD_MAX;
                        if (cv < RD_MIN) cv = RD_MIN;
                    end
                end
                r.covariance_value = cv[47:0];
                r.sample_count = count_sh[15:0];
                r.empty_res = (count_sh == 0);
                r.overflow = ovf_sh;
            end
            default: ;
        endcase
    endtask

    // Directed table. A row with chk set carries its expected result.
    typedef struct {
        cmd_t c;
        bit   chk;
        res_t r;
    } vec_row_t;

    vec_row_t directed [$];

    function automatic cmd_t mk(input action_t a, input logic [15:0] v,
                                input int rw, input int cl);
        cmd_t c;
        c.action = a;
        c.value = v;
        c.row = rw[2:0];
        c.col = cl[2:0];
        return c;
    endfunction

    function automatic res_t empty_result();
        res_t r;
        r = '0;
        r.empty_res = 1'b1;
        return r;
    endfunction

    task automatic build_table();
        // Read straight after reset: everything zero and flagged empty.
        directed.push_back('{mk(ACT_READ, 16'h0, 0, 0), 1'b1, empty_result()});
        directed.push_back('{mk(ACT_READ, 16'h0, 7, 7), 1'b1, empty_result()});
        // Unused action code is ignored.
        directed.push_back('{mk(ACT_NONE, 16'hFFFF, 7, 7), 1'b0, '0});
        // One vector of extreme values, alternating sign.
        for (int k = 0; k < 8; k++)
            directed.push_back('{mk(ACT_SAMPLE, k[0] ? 16'h8000 : 16'h7FFF, 0, 0),
                                 1'b0, '0});
        directed.push_back('{mk(ACT_READ, 16'h0, 0, 1), 1'b0, '0});
        directed.push_back('{mk(ACT_READ, 16'h0, 7, 0), 1'b0, '0});
        // Second vector flips the signs so the sums grow.
        for (int k = 0; k < 8; k++)
            directed.push_back('{mk(ACT_SAMPLE, k[0] ? 16'h7FFF : 16'h8000, 0, 0),
                                 1'b0, '0});
        directed.push_back('{mk(ACT_READ, 16'h0, 3, 3), 1'b0, '0});
        // A half-written vector is thrown away by a clear.
        directed.push_back('{mk(ACT_SAMPLE, 16'h1234, 0, 0), 1'b0, '0});
        directed.push_back('{mk(ACT_CLEAR, 16'h0, 0, 0), 1'b0, '0});
        directed.push_back('{mk(ACT_READ, 16'h0, 5, 2), 1'b1, empty_result()});
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int gap_len();
        if (quiet_phase) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Drives one item at a falling edge and holds it until it is taken. Valid stays
    // high afterwards so that the next item can follow back to back.
    task automatic send_cmd(input cmd_t c, input bit chk, input res_t typed);
        bit has_res;
        res_t r;
        repeat (gap_len())
        begin
            @(negedge clk);
            cmd_valid = 1'b0;
            cmd = cmd_t'($urandom);
        end
        @(negedge clk);
        cmd_valid = 1'b1;
        cmd = c;
        do
            @(posedge clk);
        while (cmd_stall);
        predict_cmd(c, has_res, r);
        n_cmds++;
        if (has_res)
        begin
            n_reads++;
            pending_reads.push_back(chk ? typed : r);
        end
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stalls at random outside the quiet phases, falling-edge driven.
    always @(negedge clk)
    begin
        if (quiet_phase)
            res_stall <= 1'b0;
        else if ($urandom_range(0, 39) == 0)
            res_stall <= 1'b1;
        else if (res_stall && $urandom_range(0, 7) != 0)
            res_stall <= 1'b1;
        else
            res_stall <= ($urandom_range(0, 3) == 0);
    end

    // Result checker and idle watchdog.
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
        if (res_valid && !res_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("result item with no read waiting");
                errors++;
            end
            else
            begin
                e = pending_reads.pop_front();
                if (res.mean_value !== e.mean_value)
                begin
                    $error("mean_value exp %0d got %0d", e.mean_value, res.mean_value);
                    errors++;
                end
                if (res.covariance_value !== e.covariance_value)
                begin
                    $error("covariance_value exp %0d got %0d",
                           e.covariance_value, res.covariance_value);
                    errors++;
                end
                if (res.sample_count !== e.sample_count)
                begin
                    $error("sample_count exp %0d got %0d", e.sample_count, res.sample_count);
                    errors++;
                end
                if (res.empty_res !== e.empty_res)
                begin
                    $error("empty_res exp %0b got %0b", e.empty_res, res.empty_res);
                    errors++;
                end
                if (res.overflow !== e.overflow)
                begin
                    $error("overflow exp %0b got %0b", e.overflow, res.overflow);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cmd_t c;
        int sent;
        for (int k = 0; k < 8; k++)
            elem_buf[k] = 0;
        stats_clear();
        build_table();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_cmd(directed[i].c, directed[i].chk, directed[i].r);

        // Random part: mostly sample elements, with reads, clears and unused codes
        // mixed in at random.
        sent = 0;
        while (sent < N_RANDOM)
        begin
            quiet_phase = ((sent / 100) % 3 == 2);
            if (sent > 300 && sent < 320)
            begin
                // Hold off until every read has come back.
                drain();
            end
            case ($urandom_range(0, 19))
                0: c = mk(ACT_CLEAR, 16'($urandom), $urandom, $urandom);
                1: c = mk(ACT_NONE, 16'($urandom), $urandom, $urandom);
                2, 3, 4, 5: c = mk(ACT_READ, 16'($urandom), $urandom, $urandom);
                default: c = mk(ACT_SAMPLE, rand_value(), $urandom, $urandom);
            endcase
            send_cmd(c, 1'b0, '0);
            sent++;
        end

        drain();
        repeat (400) @(posedge clk);
        $display("Covered %0d commands, %0d reads checked, %0d vectors folded in.",
                 n_cmds, n_reads, n_vectors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ocv_pkg.sv
hw/rtl/ocv_ram.sv
hw/rtl/ocv_div.sv
hw/rtl/online_mean_covariance_unit.sv
hw/rtl/ocv_checker.sv
sim/tb_online_mean_covariance_unit.sv
